[hdl/psu_pkg.sv]
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants of the PNG scanline unfilter
// Holds the request structs, filter type codes and size constants.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int MAX_ROW_BYTES   = 16384;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int POS_W           = $clog2(MAX_ROW_BYTES);
  localparam int ROW_W           = 15;
  localparam int BPP_W           = 4;
  localparam int BIDX_W          = $clog2(MAX_PIXEL_BYTES) > 0 ? $clog2(MAX_PIXEL_BYTES) : 1;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [0:0] REG_BPP = 1'b0;
  localparam logic [0:0] REG_ROW = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_end;
    logic       bad_filter;
  } out_item_t;

  // Decoded request held in the input register.
  typedef struct packed {
    logic              emit;
    logic              err;
    logic              clear;
    logic [7:0]        data;
    logic [2:0]        filt;
    logic              first_row;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic [BIDX_W-1:0] bidx;
  } stage_t;

endpackage

[hdl/png_scanline_unfilter.sv]
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG filter reconstruction, one byte per unstalled cycle
// Rebuilds None, Sub, Up, Average and Paeth filtered rows from a byte stream.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_stall    in_data  (in_item_t)
//   out       output      out_valid / out_stall  out_data (out_item_t)
//   cfg       input       cfg_we                 cfg_index, cfg_data
//
// Each accepted request is held in the input register and the rebuilt byte
// then goes into the output register; one request is taken every cycle
// while the output is not stalled. The rate is set by the single read port
// of the line store, which is read when a request enters.
// Reset is synchronous; the line store itself is not cleared, the first row
// of every image reads the row above as zero instead.
// A stalled output holds its result; the input register keeps taking requests
// that give no result, and stalls the input only when a result cannot move on.
module png_scanline_unfilter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  psu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output psu_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import psu_pkg::*;

  // Configuration registers.
  logic [BPP_W-1:0] bytes_per_pixel;
  logic [ROW_W-1:0] row_bytes;

  // Control state, updated when a request is accepted.
  logic             failed, failed_next;
  logic             await_filter, await_filter_next;
  logic             on_first_row, on_first_row_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [2:0]       filter_kind, filter_kind_next;

  // Input register, line store read data and output register.
  logic       s1_valid;
  stage_t     s1, s1_next;
  logic [7:0] above;
  out_item_t  out_next;

  // Last bytes of this row and of the row above, newest first.
  logic [7:0] left_bytes [MAX_PIXEL_BYTES];
  logic [7:0] upper_left_bytes [MAX_PIXEL_BYTES];

  logic [7:0] line_store [MAX_ROW_BYTES];

  logic in_acc, adv, mem_we;
  logic [POS_W-1:0] rd_addr;

  assign adv      = s1_valid && (!s1.emit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign mem_we   = adv && s1.emit && !s1.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(1);
      row_bytes       <= ROW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BPP: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_ROW: row_bytes       <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode of the incoming request: all control state moves here, since
  // none of it depends on the rebuilt byte.
  logic             img, f_eff, aw_eff, fr_eff;
  logic [POS_W-1:0] pos_eff;
  logic [ROW_W-1:0] eff_row;
  logic [ROW_W-1:0] pos_plus;
  logic [BIDX_W-1:0] bidx;

  always_comb begin
    img     = in_data.new_image;
    f_eff   = img ? 1'b0 : failed;
    aw_eff  = img ? 1'b1 : await_filter;
    fr_eff  = img ? 1'b1 : on_first_row;
    pos_eff = img ? '0 : byte_position;

    if (row_bytes == '0) begin
      eff_row = ROW_W'(1);
    end else if (row_bytes > ROW_W'(MAX_ROW_BYTES)) begin
      eff_row = ROW_W'(MAX_ROW_BYTES);
    end else begin
      eff_row = row_bytes;
    end

    if (bytes_per_pixel == '0) begin
      bidx = '0;
    end else if (bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) begin
      bidx = BIDX_W'(MAX_PIXEL_BYTES - 1);
    end else begin
      bidx = BIDX_W'(bytes_per_pixel - BPP_W'(1));
    end

    pos_plus = ROW_W'(pos_eff) + ROW_W'(1);

    failed_next        = f_eff;
    await_filter_next  = aw_eff;
    on_first_row_next  = fr_eff;
    byte_position_next = pos_eff;
    filter_kind_next   = filter_kind;

    s1_next.emit      = 1'b0;
    s1_next.err       = 1'b0;
    s1_next.clear     = img || (!failed && await_filter);
    s1_next.data      = in_data.in_byte;
    s1_next.filt      = filter_kind;
    s1_next.first_row = fr_eff;
    s1_next.pos       = pos_eff;
    s1_next.last      = 1'b0;
    s1_next.bidx      = bidx;

    if (f_eff) begin
      // Stopped after a bad filter type: the request is dropped.
    end else if (aw_eff) begin
      if (in_data.in_byte > 8'(FILT_PAETH)) begin
        failed_next  = 1'b1;
        s1_next.emit = 1'b1;
        s1_next.err  = 1'b1;
      end else begin
        filter_kind_next   = in_data.in_byte[2:0];
        await_filter_next  = 1'b0;
        byte_position_next = '0;
      end
    end else begin
      s1_next.emit = 1'b1;
      if (pos_plus >= eff_row) begin
        s1_next.last       = 1'b1;
        await_filter_next  = 1'b1;
        on_first_row_next  = 1'b0;
        byte_position_next = '0;
      end else begin
        byte_position_next = pos_plus[POS_W-1:0];
      end
    end
  end

  assign rd_addr = pos_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      failed        <= 1'b0;
      await_filter  <= 1'b1;
      on_first_row  <= 1'b1;
      byte_position <= '0;
      filter_kind   <= FILT_NONE;
    end else if (in_acc) begin
      failed        <= failed_next;
      await_filter  <= await_filter_next;
      on_first_row  <= on_first_row_next;
      byte_position <= byte_position_next;
      filter_kind   <= filter_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1 <= s1_next;
    end
  end

  // Line store: one write port for the rebuilt byte, one registered read
  // port that fetches the byte above as the request enters. A read never
  // meets a write to the same entry, because a filter byte always sits
  // between the last byte of a row and the first byte of the next.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[s1.pos] <= out_next.out_byte;
    end
    if (in_acc) begin
      above <= line_store[rd_addr];
    end
  end

  // Reconstruction between the input register and the output register.
  logic [7:0] a, b, c, pred;
  logic [8:0] sum_ab;
  logic [9:0] pa, pb, pc;
  logic signed [9:0] d_bc, d_ac, d_abc;

  always_comb begin
    a      = left_bytes[s1.bidx];
    c      = upper_left_bytes[s1.bidx];
    b      = s1.first_row ? 8'd0 : above;
    sum_ab = {1'b0, a} + {1'b0, b};
    d_bc   = $signed({2'b00, b}) - $signed({2'b00, c});
    d_ac   = $signed({2'b00, a}) - $signed({2'b00, c});
    d_abc  = $signed({1'b0, sum_ab}) - $signed({1'b0, c, 1'b0});
    pa     = d_bc[9] ? 10'(-d_bc) : 10'(d_bc);
    pb     = d_ac[9] ? 10'(-d_ac) : 10'(d_ac);
    pc     = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);

    case (s1.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase

    if (s1.err) begin
      out_next.out_byte   = 8'd0;
      out_next.row_end    = 1'b0;
      out_next.bad_filter = 1'b1;
    end else begin
      out_next.out_byte   = s1.data + pred;
      out_next.row_end    = s1.last;
      out_next.bad_filter = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_bytes[k]       <= 8'd0;
        upper_left_bytes[k] <= 8'd0;
      end
    end else if (adv && s1.clear) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_bytes[k]       <= 8'd0;
        upper_left_bytes[k] <= 8'd0;
      end
    end else if (mem_we) begin
      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_bytes[k]       <= left_bytes[k-1];
        upper_left_bytes[k] <= upper_left_bytes[k-1];
      end
      left_bytes[0]       <= out_next.out_byte;
      upper_left_bytes[0] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1.emit) begin
      out_data <= out_next;
    end
  end

  // The input only stalls while the input register holds a request.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  // An error result carries a zero byte and no row end.
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bad_filter) |->
      (out_data.out_byte == 8'd0 && !out_data.row_end))
    else $error("error result with payload bits set");

  // A data request entering never reads the entry being written.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && in_acc && !f_eff && !aw_eff) |-> (rd_addr != s1.pos))
    else $error("line store read and write on the same entry");

  // Output never changes a stalled result by loading a new one.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(adv && s1.emit))
    else $error("result overwritten while stalled");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for png_scanline_unfilter
// Streams filter-type and data bytes through the unfilter and compares every
// rebuilt byte against a cycle-free predictor of the None, Sub, Up, Average
// and Paeth reconstruction. The register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
  import psu_pkg::*;

  // The first filter code that the block must reject.
  localparam logic [7:0] FILT_FIRST_BAD = 8'd5;

  // Cycles to let pass once the last expected byte is out. A filter byte
  // gives no result but may still sit in the two-stage pipeline.
  localparam int SETTLE_CYCLES = 4;
  // The run is declared hung after this many cycles without any transfer.
  localparam int STALL_LIMIT   = 5000;
  // Long receiver hold-offs that back the pipeline up into the input.
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_SPACING  = 9000;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_BPP;
  logic [14:0] cfg_data = '0;

  always #5 clk = ~clk;

  png_scanline_unfilter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Requests waiting to be offered, and rebuilt bytes waiting to come out.
  in_item_t  stream_q[$];
  out_item_t rebuilt_q[$];
  int        errors = 0;

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the registers as written and the row context
  // of the unfilter: the row above, the recent bytes of the current row and
  // of the row above (newest first), and the position inside the row.
  // --------------------------------------------------------------------------
  logic [3:0]  cfg_bpp = 4'd1;
  logic [14:0] cfg_row = 15'd1;
  logic [7:0]  prev_row [MAX_ROW_BYTES];
  logic [7:0]  left_hist [MAX_PIXEL_BYTES];
  logic [7:0]  upleft_hist [MAX_PIXEL_BYTES];
  int          col_pos = 0;
  logic [2:0]  filt = FILT_NONE;
  bit          want_filter = 1'b1;
  bit          first_row = 1'b1;
  bit          halted = 1'b0;
  // Entries below this index of the row store have been written since reset.
  // The stimulus never lets a row other than an image's first read above it.
  int          store_hi = 0;

  initial begin
    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
      left_hist[k] = 8'h00;
      upleft_hist[k] = 8'h00;
    end
  end

  // A zero row length acts as one, and anything past the store depth is
  // clipped to it.
  function automatic int row_len_eff();
    if (cfg_row == 15'd0) return 1;
    if (cfg_row > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return int'(cfg_row);
  endfunction

  function automatic void restart_row();
    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
      left_hist[k] = 8'h00;
      upleft_hist[k] = 8'h00;
    end
    col_pos = 0;
  endfunction

  // Works out what one accepted request produces and queues it.
  function automatic void unfilter_step(in_item_t req);
    int bpp, pos, a, b, c, p, pa, pb, pc, pred;
    logic [7:0] r;
    bit last;
    out_item_t res;
    if (req.new_image) begin
      halted = 1'b0;
      first_row = 1'b1;
      want_filter = 1'b1;
      restart_row();
    end
    if (halted) return;
    if (want_filter) begin
      if (req.in_byte > FILT_PAETH) begin
        // A bad filter code reports once and then mutes the stream.
        halted = 1'b1;
        res.out_byte = 8'h00;
        res.row_end = 1'b0;
        res.bad_filter = 1'b1;
        rebuilt_q.push_back(res);
        return;
      end
      filt = req.in_byte[2:0];
      want_filter = 1'b0;
      restart_row();
      return;
    end
    bpp = (cfg_bpp == 4'd0) ? 1 :
          (cfg_bpp > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(cfg_bpp);
    pos = col_pos % MAX_ROW_BYTES;
    a = left_hist[bpp-1];
    c = upleft_hist[bpp-1];
    b = first_row ? 0 : int'(prev_row[pos]);
    case (filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = (a + b) >> 1;
      FILT_PAETH: begin
        p = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = b;
        else pred = c;
      end
      default:    pred = 0;
    endcase
    r = req.in_byte + pred[7:0];
    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k] = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0] = r;
    upleft_hist[0] = b[7:0];
    prev_row[pos] = r;
    if (pos + 1 > store_hi) store_hi = pos + 1;
    // After a row length shrink the position may already be past the end,
    // and then this byte closes the row.
    last = (col_pos + 1 >= row_len_eff());
    if (last) begin
      want_filter = 1'b1;
      first_row = 1'b0;
      col_pos = 0;
    end else begin
      col_pos = col_pos + 1;
    end
    res.out_byte = r;
    res.row_end = last;
    res.bad_filter = 1'b0;
    rebuilt_q.push_back(res);
  endfunction

  function automatic void flag_mismatch(string what, out_item_t want, out_item_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected byte %02h end %0b bad %0b, got byte %02h end %0b bad %0b",
               $realtime, what, want.out_byte, want.row_end, want.bad_filter,
               got.out_byte, got.row_end, got.bad_filter);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. It offers requests from stream_q in bursts of random length with
  // random gaps in between, and holds a request steady while it is stalled.
  // --------------------------------------------------------------------------
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    bit took;
    took = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stream_q.size() > 0) begin
        in_data <= stream_q.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(48, 1);
          case ($urandom_range(7, 0))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(30, 10);
            default: gap_left = $urandom_range(6, 1);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It stalls on a pattern that changes mode at random intervals,
  // and now and then holds off for a long stretch so that the block
  // backs up and stalls its input while the driver keeps offering.
  // --------------------------------------------------------------------------
  int       results_seen = 0;
  int       next_hold = 400;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_FREE;

  always @(posedge clk) begin : receive
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) results_seen++;
      if (hold_left == 0 && results_seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + HOLD_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(3, 0));
          mode_left = $urandom_range(256, 32);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(9, 0) < 7);
          default:  out_stall <= (mode_left % 5 == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. The output is checked before the request taken at the same
  // edge is predicted; the input and output registers keep them apart,
  // and doing both in one process fixes their order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (rebuilt_q.size() == 0) begin
          flag_mismatch("unexpected result", '0, out_data);
        end else begin
          want = rebuilt_q.pop_front();
          if (out_data !== want) flag_mismatch("mismatch", want, out_data);
        end
      end
      if (in_valid && !in_stall) unfilter_step(in_data);
    end
  end

  // Ends a run in which nothing moves for too long.
  int quiet = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("png_scanline_unfilter test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [0:0] idx, logic [14:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_BPP) cfg_bpp = val[3:0];
    else cfg_row = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void push_req(logic [7:0] val, bit img);
    in_item_t req;
    req.in_byte = val;
    req.new_image = img;
    stream_q.push_back(req);
  endfunction

  // Waits until every request is taken and every rebuilt byte is out, then
  // lets the pipeline settle so that a register write finds it empty.
  task automatic wait_drained();
    while (stream_q.size() != 0 || in_valid || rebuilt_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queues well-formed rows with random content: a filter byte followed by a
  // full row of data bytes. pct_bad is the percentage of filter bytes that
  // carry a bad code, and pct_img sets how often a new image starts (at a
  // filter byte; a tenth of that in mid-row). Bytes sent while the stream is
  // muted are ignored by the block and are not counted.
  task automatic queue_stream(int n_items, int pct_bad, int pct_img);
    int made, col, rowlen;
    bit need_filter, stuck, force_img, img;
    logic [7:0] val;
    rowlen = row_len_eff();
    need_filter = want_filter;
    stuck = halted;
    col = col_pos;
    // A row longer than what the store has ever held must start an image,
    // or a later row would read entries that were never written.
    force_img = (rowlen > store_hi);
    made = 0;
    while (made < n_items) begin
      if (stuck && $urandom_range(9, 0) < 3) begin
        push_req($urandom_range(255, 0), 1'b0);
      end else begin
        img = force_img || stuck ||
              ($urandom_range(999, 0) < pct_img * (need_filter ? 10 : 1));
        force_img = 1'b0;
        if (img || need_filter) begin
          if ($urandom_range(99, 0) < pct_bad) val = $urandom_range(255, FILT_FIRST_BAD);
          else val = $urandom_range(FILT_PAETH, FILT_NONE);
          stuck = (val > FILT_PAETH);
          need_filter = stuck;
          col = 0;
        end else begin
          case ($urandom_range(7, 0))
            0:       val = 8'h00;
            1:       val = 8'hFF;
            default: val = $urandom_range(255, 0);
          endcase
          col++;
          if (col >= rowlen) begin
            need_filter = 1'b1;
            col = 0;
          end
        end
        push_req(val, img);
        made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [3:0]  bpp_v;
    logic [14:0] row_v;
    int          pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows with three bytes at two bytes per pixel: every filter
    // kind on extreme byte values, so that the row above and the left
    // neighbours come into play from the second row on.
    write_reg(REG_BPP, 15'd2);
    write_reg(REG_ROW, 15'd3);
    push_req(FILT_NONE, 1'b1);
    push_req(8'h00, 1'b0); push_req(8'hFF, 1'b0); push_req(8'h80, 1'b0);
    push_req(FILT_SUB, 1'b0);
    push_req(8'hFF, 1'b0); push_req(8'h01, 1'b0); push_req(8'h7F, 1'b0);
    push_req(FILT_UP, 1'b0);
    push_req(8'h01, 1'b0); push_req(8'hFF, 1'b0); push_req(8'h00, 1'b0);
    push_req(FILT_AVG, 1'b0);
    push_req(8'hFF, 1'b0); push_req(8'hFF, 1'b0); push_req(8'h10, 1'b0);
    push_req(FILT_PAETH, 1'b0);
    push_req(8'h55, 1'b0); push_req(8'hAA, 1'b0); push_req(8'hFF, 1'b0);
    // A bad filter code, a byte that the muted stream must ignore, and a
    // bad code on the very byte that starts a new image.
    push_req(8'hFF, 1'b0);
    push_req(8'h12, 1'b0);
    push_req(FILT_FIRST_BAD, 1'b1);
    // A new image that is cut short in mid-row by the next new image.
    push_req(FILT_PAETH, 1'b1);
    push_req(8'h7F, 1'b0);
    push_req(FILT_SUB, 1'b1);
    push_req(8'h80, 1'b0); push_req(8'h80, 1'b0); push_req(8'h80, 1'b0);
    wait_drained();

    // Random phases with small rows. The first two pin the register
    // extremes, including values outside the legal range.
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(5, 0))
        0:       bpp_v = 4'd0;
        1:       bpp_v = 4'd1;
        2:       bpp_v = 4'd8;
        3:       bpp_v = $urandom_range(15, 9);
        default: bpp_v = $urandom_range(8, 1);
      endcase
      case ($urandom_range(5, 0))
        0:       row_v = 15'd0;
        1:       row_v = 15'd1;
        2:       row_v = $urandom_range(8, 2);
        3:       row_v = $urandom_range(40, 9);
        default: row_v = $urandom_range(20, 2);
      endcase
      pick = $urandom_range(3, 0);
      if (ph == 0) begin
        bpp_v = 4'd0;
        row_v = 15'd0;
        pick = 2;
      end else if (ph == 1) begin
        bpp_v = 4'd15;
        row_v = 15'd1;
        pick = 2;
      end
      if (pick != 1) write_reg(REG_BPP, {11'd0, bpp_v});
      if (pick != 0) write_reg(REG_ROW, row_v);
      queue_stream($urandom_range(140, 80), 4, 15);
      wait_drained();
    end

    // A row length written past the legal maximum acts as the store depth,
    // so the forty bytes sent next stay inside one unfinished row. The
    // shorter row length written after them ends that row on its next byte.
    write_reg(REG_BPP, 15'd3);
    write_reg(REG_ROW, 15'h7FFF);
    queue_stream(40, 0, 0);
    wait_drained();

    write_reg(REG_BPP, 15'd15);
    write_reg(REG_ROW, 15'd3);
    queue_stream(60, 4, 15);
    wait_drained();

    // Give a stray result time to show up before the verdict.
    repeat (16) @(posedge clk);
    if (errors == 0 && rebuilt_q.size() == 0) begin
      $display("png_scanline_unfilter test passed");
    end else begin
      $display("png_scanline_unfilter test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/psu_pkg.sv
hdl/png_scanline_unfilter.sv
test/tb.sv
